// ===== hdl/lhat_pkg.sv =====
// ----------------------------------------------------------------------------
// lhat_pkg
// Shared types and constants for the live host aging table.
// ----------------------------------------------------------------------------
package lhat_pkg;

    localparam int LHAT_SLOTS = 16;

    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int COUNT_W = 5;
    localparam int KIND_W  = 3;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CFG_W-1:0] ENTRY_TTL_RST = CFG_W'(10);
    localparam logic [CFG_W-1:0] TICK_STEP_RST = CFG_W'(1);

    typedef enum logic
    {
        OP_SEEN = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic
    {
        REG_ENTRY_TTL = 1'b0,
        REG_TICK_STEP = 1'b1
    } reg_idx_t;

    typedef enum logic [KIND_W-1:0]
    {
        KIND_ADDED     = 3'd0,
        KIND_REFRESHED = 3'd1,
        KIND_DROPPED   = 3'd2,
        KIND_REMOVED   = 3'd3,
        KIND_TICK_DONE = 3'd4
    } kind_t;

    typedef struct packed
    {
        logic [CFG_W-1:0] entry_ttl;
        logic [CFG_W-1:0] tick_step;
    } cfg_t;

    typedef struct packed
    {
        kind_t              kind;
        logic [ADDR_W-1:0]  address;
        logic [PORT_W-1:0]  port;
        logic [COUNT_W-1:0] count;
        logic               last;
    } evt_t;

endpackage

// ===== hdl/lhat_engine.sv =====
// ----------------------------------------------------------------------------
// lhat_engine
// Slot table and sequencer: walks the slots one at a time through a single
// compare/subtract unit for lookups, inserts and aging.
// ----------------------------------------------------------------------------
module lhat_engine
    import lhat_pkg::*;
#(
    parameter int TABLE_SLOTS = LHAT_SLOTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              operation,
    input  logic [ADDR_W-1:0] host_address,
    input  logic [PORT_W-1:0] host_port,
    input  logic              evt_ready,
    output logic              evt_valid,
    output evt_t              evt
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    op_t                     op_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [PORT_W-1:0]       port_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    logic                    free_found_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [TABLE_SLOTS-1:0]  slot_valid_reg;

    logic [ADDR_W-1:0]       mem_addr [TABLE_SLOTS];
    logic [PORT_W-1:0]       mem_port [TABLE_SLOTS];
    logic [CFG_W-1:0]        mem_life [TABLE_SLOTS];
    logic [ADDR_W-1:0]       rd_addr_reg;
    logic [PORT_W-1:0]       rd_port_reg;
    logic [CFG_W-1:0]        rd_life_reg;

    logic [CFG_W:0]          diff;
    logic                    expire;
    logic                    cur_valid;
    logic                    hit;
    logic                    last_idx;
    logic                    accept;
    logic                    wr_all;
    logic                    wr_life;
    logic [IDX_W-1:0]        wr_idx;
    logic [CFG_W-1:0]        wr_life_val;

    // shared subtract/compare unit
    assign diff      = {1'b0, rd_life_reg} - {1'b0, cfg.tick_step};
    assign expire    = diff[CFG_W] || (diff[CFG_W-1:0] == '0);
    assign cur_valid = slot_valid_reg[idx_reg];
    assign hit       = cur_valid && (rd_addr_reg == addr_reg) && (rd_port_reg == port_reg);
    assign last_idx  = (idx_reg == IDX_W'(TABLE_SLOTS - 1));
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        wr_all      = 1'b0;
        wr_life     = 1'b0;
        wr_idx      = idx_reg;
        wr_life_val = cfg.entry_ttl;
        if (state_reg == ST_FINISH)
        begin
            wr_all = evt_ready && free_found_reg;
            wr_idx = free_idx_reg;
        end
        else if (state_reg == ST_EVAL)
        begin
            if (op_reg == OP_SEEN)
            begin
                wr_life = hit && evt_ready;
            end
            else
            begin
                wr_life     = cur_valid && !expire;
                wr_life_val = diff[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_all)
        begin
            mem_addr[wr_idx] <= addr_reg;
            mem_port[wr_idx] <= port_reg;
        end
        if (wr_all || wr_life)
        begin
            mem_life[wr_idx] <= wr_life_val;
        end
        if (state_reg == ST_READ)
        begin
            rd_addr_reg <= mem_addr[idx_reg];
            rd_port_reg <= mem_port[idx_reg];
            rd_life_reg <= mem_life[idx_reg];
        end
    end

    always_comb
    begin
        evt_valid   = 1'b0;
        evt.kind    = KIND_TICK_DONE;
        evt.address = '0;
        evt.port    = '0;
        evt.count   = COUNT_W'(count_reg);
        evt.last    = 1'b1;
        unique case (state_reg)
            ST_EVAL:
            begin
                if (op_reg == OP_SEEN)
                begin
                    evt_valid   = hit;
                    evt.kind    = KIND_REFRESHED;
                    evt.address = addr_reg;
                    evt.port    = port_reg;
                end
                else
                begin
                    evt_valid   = cur_valid && expire;
                    evt.kind    = KIND_REMOVED;
                    evt.address = rd_addr_reg;
                    evt.port    = rd_port_reg;
                    evt.count   = COUNT_W'(count_reg - CNT_W'(1));
                    evt.last    = 1'b0;
                end
            end
            ST_FINISH:
            begin
                evt_valid   = 1'b1;
                evt.address = addr_reg;
                evt.port    = port_reg;
                if (free_found_reg)
                begin
                    evt.kind  = KIND_ADDED;
                    evt.count = COUNT_W'(count_reg + CNT_W'(1));
                end
                else
                begin
                    evt.kind = KIND_DROPPED;
                end
            end
            ST_DONE:
            begin
                evt_valid = 1'b1;
            end
            default:
            begin
                evt_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_SEEN;
            addr_reg       <= '0;
            port_reg       <= '0;
            idx_reg        <= '0;
            free_idx_reg   <= '0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
            slot_valid_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg         <= op_t'(operation);
                        addr_reg       <= host_address;
                        port_reg       <= host_port;
                        idx_reg        <= '0;
                        free_found_reg <= 1'b0;
                        state_reg      <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (op_reg == OP_SEEN)
                    begin
                        if (hit)
                        begin
                            if (evt_ready)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        else
                        begin
                            if (!cur_valid && !free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= idx_reg;
                            end
                            if (last_idx)
                            begin
                                state_reg <= ST_FINISH;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + IDX_W'(1);
                                state_reg <= ST_READ;
                            end
                        end
                    end
                    else if (!(cur_valid && expire) || evt_ready)
                    begin
                        if (cur_valid && expire)
                        begin
                            slot_valid_reg[idx_reg] <= 1'b0;
                            count_reg               <= count_reg - CNT_W'(1);
                        end
                        if (last_idx)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (evt_ready)
                    begin
                        if (free_found_reg)
                        begin
                            slot_valid_reg[free_idx_reg] <= 1'b1;
                            count_reg                    <= count_reg + CNT_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DONE:
                begin
                    if (evt_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/live_host_aging_table.sv =====
// ----------------------------------------------------------------------------
// live_host_aging_table
// Table of live senders keyed by address and port, each with a lifetime.
// Packet words refresh or add a sender; tick words age and expire entries.
//
//   channel   handshake                  payload
//   cfg       psel/penable/pwrite/pready paddr, pwdata, prdata
//   in        in_valid/in_ready          operation, host_address, host_port
//   out       out_valid/out_ready        event_kind, event_address, event_port,
//                                        live_count, last_of_run
//
// Each slot visit is a memory read (ST_READ), then a compare/subtract
// (ST_EVAL), so a packet word walks up to every slot and a tick word walks
// every slot, plus any output stalls; a refresh ends at its hit.
// in_ready is high only between words. Reset clears all slot valid bits at
// once; no clearing pass. An output register lets the next word start while
// the last result is still waiting.
// ----------------------------------------------------------------------------
module live_host_aging_table
    import lhat_pkg::*;
#(
    parameter int TABLE_SLOTS = LHAT_SLOTS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [ADDR_W-1:0]  host_address,
    input  logic [PORT_W-1:0]  host_port,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  event_kind,
    output logic [ADDR_W-1:0]  event_address,
    output logic [PORT_W-1:0]  event_port,
    output logic [COUNT_W-1:0] live_count,
    output logic               last_of_run
);

    cfg_t     cfg_reg;
    logic     out_valid_reg;
    evt_t     out_evt_reg;
    logic     evt_valid;
    logic     evt_ready;
    evt_t     evt;
    reg_idx_t reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[2]);
    assign evt_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (reg_sel)
            REG_ENTRY_TTL: prdata = PDATA_W'(cfg_reg.entry_ttl);
            REG_TICK_STEP: prdata = PDATA_W'(cfg_reg.tick_step);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_ttl <= ENTRY_TTL_RST;
            cfg_reg.tick_step <= TICK_STEP_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                REG_ENTRY_TTL: cfg_reg.entry_ttl <= pwdata[CFG_W-1:0];
                REG_TICK_STEP: cfg_reg.tick_step <= pwdata[CFG_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    lhat_engine #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .host_address (host_address),
        .host_port    (host_port),
        .evt_ready    (evt_ready),
        .evt_valid    (evt_valid),
        .evt          (evt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_evt_reg   <= '0;
        end
        else if (evt_ready)
        begin
            out_valid_reg <= evt_valid;
            if (evt_valid)
            begin
                out_evt_reg <= evt;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_evt_reg.kind;
    assign event_address = out_evt_reg.address;
    assign event_port    = out_evt_reg.port;
    assign live_count    = out_evt_reg.count;
    assign last_of_run   = out_evt_reg.last;

endmodule

// ===== hdl/lhat_checker.sv =====
// ----------------------------------------------------------------------------
// lhat_checker
// Port-level checks on the live host aging table, bound to the top level.
// ----------------------------------------------------------------------------
module lhat_checker
    import lhat_pkg::*;
#(
    parameter int TABLE_SLOTS = LHAT_SLOTS
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [KIND_W-1:0]  event_kind,
    input logic [ADDR_W-1:0]  event_address,
    input logic [PORT_W-1:0]  event_port,
    input logic [COUNT_W-1:0] live_count,
    input logic               last_of_run
);

    // one word in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high right after an accepted word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (TABLE_SLOTS < 32)) |-> (32'(live_count) <= 32'(TABLE_SLOTS)))
        else $error("live_count above table size");

    a_tick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_kind == KIND_TICK_DONE)) |->
        (last_of_run && (event_address == '0) && (event_port == '0)))
        else $error("tick done word malformed");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_run == (event_kind != KIND_REMOVED)))
        else $error("last_of_run does not match event kind");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(event_kind) && $stable(event_address)))
        else $error("stalled output word changed");

endmodule

bind live_host_aging_table lhat_checker #(
    .TABLE_SLOTS (TABLE_SLOTS)
) u_lhat_checker (.*);
